// ===== hdl/cigar_read_to_ref_position_assert.svh =====
// ---------------------------------------------------------------------------
// CIGAR read-to-reference lift: assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef CIGAR_READ_TO_REF_POSITION_ASSERT_SVH
`define CIGAR_READ_TO_REF_POSITION_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define CRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/crp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crp_pkg
// Types and constants shared by the CIGAR read-to-reference lift modules.
// ---------------------------------------------------------------------------
package crp_pkg;

  // Item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // SAM operation codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // Field widths
  localparam int CODE_W    = 4;
  localparam int LEN_W     = 28;
  localparam int START_W   = 31;
  localparam int OP_WORD_W = LEN_W + CODE_W;

  // Answer constants
  localparam logic [31:0] REF_NONE  = 32'hFFFF_FFFF;
  localparam logic [30:0] REF_SAT   = 31'h7FFF_FFFF;
  localparam logic [31:0] READ_SAT  = 32'hFFFF_FFFF;

  // Classified item; arg is the operation length for loads and the read
  // position for queries
  typedef struct packed {
    logic               is_query;
    logic               first_op;
    logic [CODE_W-1:0]  op_code;
    logic [LEN_W-1:0]   arg;
    logic [START_W-1:0] start_pos;
  } crp_item_t;

  // Walker states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESP
  } crp_state_t;

endpackage

// ===== hdl/crp_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module crp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/crp_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crp_front
// Accepts input beats, classifies them into load or query items and holds
// them in a two-entry queue for the walker.
// ---------------------------------------------------------------------------
module crp_front import crp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic               first_op,
  input  logic [CODE_W-1:0]  op_code,
  input  logic [LEN_W-1:0]   op_len,
  input  logic [START_W-1:0] start_pos,
  input  logic [LEN_W-1:0]   read_pos,
  output logic               head_valid,
  output crp_item_t          head,
  input  logic               pop
);

  crp_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  crp_item_t  item_in;

  // Classify the incoming beat; queries carry the read position in arg
  always_comb begin
    item_in.is_query  = (kind == KIND_QUERY);
    item_in.first_op  = first_op;
    item_in.op_code   = op_code;
    item_in.arg       = (kind == KIND_QUERY) ? read_pos : op_len;
    item_in.start_pos = start_pos;
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/crp_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crp_back
// Carries out queued items: loads write the operation store, queries walk
// the CIGAR from the current pointer and answer through an output register.
// ---------------------------------------------------------------------------
module crp_back import crp_pkg::*; #(
  parameter int MAX_OPS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  crp_item_t   head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] ref_pos,
  output logic        store_overflow
);

  localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int CW = $clog2(MAX_OPS + 1);

  crp_state_t state, state_next;

  logic [CW-1:0]      op_count, op_count_next;
  logic [CW-1:0]      walk_index, walk_index_next;
  logic [30:0]        ref_cursor, ref_cursor_next;
  logic [31:0]        read_cursor, read_cursor_next;
  logic               walk_stopped, walk_stopped_next;
  logic               overflow_flag, overflow_flag_next;
  logic [LEN_W-1:0]   query_pos, query_pos_next;
  logic [31:0]        res_pos, res_pos_next;
  logic               res_ovf, res_ovf_next;
  logic               out_load;

  // Store ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [OP_WORD_W-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [OP_WORD_W-1:0] ram_rdata;

  // Walk datapath
  logic [CODE_W-1:0] cur_code;
  logic [LEN_W-1:0]  cur_len;
  logic [31:0]       ref_sum;
  logic [30:0]       ref_add;
  logic [32:0]       read_sum;
  logic [31:0]       read_add;
  logic              run_ends_past;
  logic [33:0]       lift_raw;
  logic [31:0]       lift_val;
  logic [CW-1:0]     load_slot;
  logic [CW-1:0]     index_inc;

  crp_ram #(
    .WIDTH (OP_WORD_W),
    .DEPTH (MAX_OPS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode the fetched operation and form cursor sums
  assign cur_code      = ram_rdata[CODE_W-1:0];
  assign cur_len       = ram_rdata[OP_WORD_W-1:CODE_W];
  assign ref_sum       = {1'b0, ref_cursor} + {4'b0, cur_len};
  assign ref_add       = ref_sum[31] ? REF_SAT : ref_sum[30:0];
  assign read_sum      = {1'b0, read_cursor} + {5'b0, cur_len};
  assign read_add      = read_sum[32] ? READ_SAT : read_sum[31:0];
  assign run_ends_past = (read_sum > {5'b0, query_pos});
  assign index_inc     = walk_index + CW'(1);

  // Reference position inside a match run: clamp to -1 below zero,
  // saturate above the top of the signed range
  assign lift_raw = {3'b0, ref_cursor} + {6'b0, query_pos} - {2'b0, read_cursor};
  always_comb begin
    if (lift_raw[33]) begin
      lift_val = REF_NONE;
    end else if (lift_raw[32:31] != 2'b00) begin
      lift_val = {1'b0, REF_SAT};
    end else begin
      lift_val = lift_raw[31:0];
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next         = state;
    op_count_next      = op_count;
    walk_index_next    = walk_index;
    ref_cursor_next    = ref_cursor;
    read_cursor_next   = read_cursor;
    walk_stopped_next  = walk_stopped;
    overflow_flag_next = overflow_flag;
    query_pos_next     = query_pos;
    res_pos_next       = res_pos;
    res_ovf_next       = res_ovf;
    pop                = 1'b0;
    out_load           = 1'b0;
    ram_we             = 1'b0;
    load_slot          = head.first_op ? '0 : op_count;
    ram_waddr          = load_slot[AW-1:0];
    ram_wdata          = {head.arg, head.op_code};
    ram_raddr          = walk_index[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (!head.is_query) begin
            // Load: restart on a first operation, then append or overflow
            if (head.first_op) begin
              walk_index_next    = '0;
              ref_cursor_next    = head.start_pos;
              read_cursor_next   = '0;
              walk_stopped_next  = 1'b0;
              overflow_flag_next = 1'b0;
              op_count_next      = '0;
            end
            if (load_slot < CW'(MAX_OPS)) begin
              ram_we        = 1'b1;
              op_count_next = load_slot + CW'(1);
            end else begin
              overflow_flag_next = 1'b1;
            end
          end else begin
            // Query: answer at once or start fetching at the walk pointer
            query_pos_next = head.arg;
            res_pos_next   = REF_NONE;
            res_ovf_next   = overflow_flag;
            if (overflow_flag || walk_stopped || (walk_index >= op_count)) begin
              state_next = ST_RESP;
            end else begin
              state_next = ST_EVAL;
            end
          end
        end
      end

      ST_EVAL: begin
        // Settle the fetched operation; fetch the next one when passing it
        case (cur_code) inside
          OP_M, OP_EQ, OP_X: begin
            if (run_ends_past) begin
              res_pos_next = lift_val;
              state_next   = ST_RESP;
            end else begin
              ref_cursor_next  = ref_add;
              read_cursor_next = read_add;
            end
          end
          OP_I, OP_S: begin
            if (run_ends_past) begin
              state_next = ST_RESP;
            end else begin
              read_cursor_next = read_add;
            end
          end
          OP_D, OP_N: begin
            ref_cursor_next = ref_add;
          end
          OP_H, OP_P: begin
          end
          default: begin
            walk_stopped_next = 1'b1;
            state_next        = ST_RESP;
          end
        endcase
        if (state_next == ST_EVAL) begin
          walk_index_next = index_inc;
          ram_raddr       = index_inc[AW-1:0];
          if (index_inc >= op_count) begin
            state_next = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // Hand the answer to the output register once it is free
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op_count      <= '0;
      walk_index    <= '0;
      ref_cursor    <= '0;
      read_cursor   <= '0;
      walk_stopped  <= 1'b0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      op_count      <= op_count_next;
      walk_index    <= walk_index_next;
      ref_cursor    <= ref_cursor_next;
      read_cursor   <= read_cursor_next;
      walk_stopped  <= walk_stopped_next;
      overflow_flag <= overflow_flag_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    query_pos <= query_pos_next;
    res_pos   <= res_pos_next;
    res_ovf   <= res_ovf_next;
    if (out_load) begin
      ref_pos        <= res_pos;
      store_overflow <= res_ovf;
    end
  end

endmodule

// ===== hdl/cigar_read_to_ref_position.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cigar_read_to_ref_position
// Lifts read positions of one alignment to 0-based reference positions.
// ---------------------------------------------------------------------------
// Beats with kind 0 load CIGAR operations (first_op starts a new alignment at
// start_pos); beats with kind 1 query a read position, given in nondecreasing
// order, and each query returns one result: ref_pos, or -1 when the position
// falls in an insertion or soft clip, past the last operation, after an
// unknown code, or (with store_overflow set) when the alignment had more than
// MAX_OPS operations. Beats enter a two-entry queue and are executed in order.
// A query walks the operations it examines, one operation per cycle, from
// the registered read port of the operation store; since the walk pointer
// only moves forward, each query resumes where the previous one stopped.
// The store needs no clearing after reset.
module cigar_read_to_ref_position import crp_pkg::*; #(
  parameter int MAX_OPS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic               first_op,
  input  logic [CODE_W-1:0]  op_code,
  input  logic [LEN_W-1:0]   op_len,
  input  logic [START_W-1:0] start_pos,
  input  logic [LEN_W-1:0]   read_pos,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] ref_pos,
  output logic               store_overflow
);

  logic      head_valid;
  crp_item_t head;
  logic      pop;
  logic [31:0] ref_pos_bits;

  // Accept and classify
  crp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .first_op   (first_op),
    .op_code    (op_code),
    .op_len     (op_len),
    .start_pos  (start_pos),
    .read_pos   (read_pos),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Store operations and walk
  crp_back #(
    .MAX_OPS (MAX_OPS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .ref_pos        (ref_pos_bits),
    .store_overflow (store_overflow)
  );

  assign ref_pos = signed'(ref_pos_bits);

endmodule

// ===== hdl/crp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crp_checker
// Port-level checks for the CIGAR read-to-reference lift, bound to the top.
// ---------------------------------------------------------------------------
`include "cigar_read_to_ref_position_assert.svh"

module crp_checker import crp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] ref_pos,
  input logic        store_overflow
);

  // Hold a stalled result beat
  `CRP_ASSERT_NOW(a_result_hold, $past(result_valid && !result_ready) && !$past(rst), result_valid && $stable(ref_pos) && $stable(store_overflow), "result beat changed while stalled")

  // Overflowed alignments answer -1
  `CRP_ASSERT_NOW(a_overflow_none, result_valid && store_overflow, ref_pos == REF_NONE, "overflow result is not -1")

  // The only negative answer is -1
  `CRP_ASSERT_NOW(a_neg_is_none, result_valid && ref_pos[31], ref_pos == REF_NONE, "negative answer other than -1")

  // Reset drops any pending result
  `CRP_ASSERT_NEXT(a_reset_clear, rst, !result_valid, "result valid after reset")

endmodule

bind cigar_read_to_ref_position crp_checker u_crp_checker (.*);
